// ===== hw/rtl/wsm_pkg.sv =====
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types, constants and helpers for the wildcard substring matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsm_pkg;

  // Pattern storage as fixed by the register map
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned PAT_CHARS_ALL = 16;
  localparam int unsigned PAT_BITS      = PAT_CHARS_ALL * CHAR_W;
  localparam int unsigned PAT_MAX_DEF   = 16;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned POS_W         = 16;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_ADDR_W    = 2;

  localparam logic [CHAR_W-1:0] WILDCARD_CHAR = 8'h2E;
  localparam logic [POS_W-1:0]  POS_TOP       = {POS_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  // One result of a finished text
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_end;
  } wsm_result_t;

  // Fold ASCII upper-case letters to lower case; other bytes pass unchanged
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if ((c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/wildcard_substring_matcher_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_substring_matcher_top
// Streaming case-insensitive substring search with '.' wildcards.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock and never pauses on its own: a
// byte enters the input register, the shift-and update and first-match
// record are done from there as it leaves, and on the byte flagged tlast the
// result is loaded into the output register as that byte leaves the input
// register. The input stage only stalls while a finished result sits in
// the output register unaccepted and another final byte wants to replace it.
// The result tdata carries found in bit 0 and the 0-based position of the
// last byte of the first match in bits 16:1 (zero when nothing was found);
// positions saturate at 65535. Configuration is written through a simple
// write port and should only be changed between texts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_substring_matcher_top #(
  parameter int unsigned PATTERN_MAX = wsm_pkg::PAT_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [wsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // text input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] text_char
  input  logic                           in_tlast,   // last_char
  // result output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata   // [0] found, [16:1] match_end
);
  import wsm_pkg::*;

  logic [CFG_DATA_W-1:0] pat_low_r, pat_high_r;
  logic [LEN_W-1:0]      pat_len_r;

  logic                  s1_valid_r;
  logic [CHAR_W-1:0]     s1_char_r;
  logic                  s1_last_r;
  logic                  s1_adv;

  logic                  out_valid_r;
  wsm_result_t           out_res_r;

  logic [PATTERN_MAX-1:0] eq_vec;
  wsm_result_t            step_res;
  logic                   in_xfer;

  // Capture configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        REG_PAT_HIGH: pat_high_r <= cfg_wdata;
        REG_PAT_LEN:  pat_len_r  <= cfg_wdata[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // A byte leaves stage 1 unless it is final and the result slot is blocked
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  wsm_char_cmp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cmp (
    .text_char     (s1_char_r),
    .pattern_chars ({pat_high_r, pat_low_r}),
    .eq_vec        (eq_vec)
  );

  wsm_search #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_search (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_adv),
    .last_char      (s1_last_r),
    .eq_vec         (eq_vec),
    .pattern_length (pat_len_r),
    .result         (step_res)
  );

  // Result register: load on a final byte, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.match_end, out_res_r.found};

  // A final byte that leaves stage 1 produces a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> out_valid_r)
    else $error("final byte produced no result");

  // Only a blocked final byte may hold off the input
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && s1_last_r && out_valid_r && !out_tready)
    else $error("input stalled without a blocked result");

  // Non-final bytes never touch the result register
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !(s1_adv && s1_last_r) |=> !out_valid_r)
    else $error("result appeared without a final byte");

endmodule

// ===== hw/rtl/wsm_char_cmp.sv =====
// ----------------------------------------------------------------------------
// wsm_char_cmp
// Compares one text byte against every pattern character at once and
// returns the per-position equality vector used by the shift-and update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsm_char_cmp #(
  parameter int unsigned PATTERN_MAX = wsm_pkg::PAT_MAX_DEF
) (
  input  logic [wsm_pkg::CHAR_W-1:0]   text_char,
  input  logic [wsm_pkg::PAT_BITS-1:0] pattern_chars,
  output logic [PATTERN_MAX-1:0]       eq_vec
);
  import wsm_pkg::*;

  logic [CHAR_W-1:0] text_folded;

  assign text_folded = fold_case(text_char);

  // Match each position: wildcard takes any byte, otherwise case-folded compare
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq_vec[i] = (pattern_chars[i*CHAR_W +: CHAR_W] == WILDCARD_CHAR) ||
                  (fold_case(pattern_chars[i*CHAR_W +: CHAR_W]) == text_folded);
    end
  end

endmodule

// ===== hw/rtl/wsm_search.sv =====
// ----------------------------------------------------------------------------
// wsm_search
// Per-text search state: shift-and vector, saturating byte position, found
// flag and first match end. Advances by one byte on each step strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsm_search #(
  parameter int unsigned PATTERN_MAX = wsm_pkg::PAT_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       last_char,
  input  logic [PATTERN_MAX-1:0]     eq_vec,
  input  logic [wsm_pkg::LEN_W-1:0]  pattern_length,
  output wsm_pkg::wsm_result_t       result
);
  import wsm_pkg::*;

  logic [PATTERN_MAX-1:0] match_vec_r, match_vec_nxt, shifted;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   found_r, found_nxt;
  logic [POS_W-1:0]       end_r, end_nxt;
  logic                   hit;

  // Shift in a fresh start bit and keep only positions that still agree
  always_comb begin
    shifted = (match_vec_r << 1) | {{(PATTERN_MAX-1){1'b0}}, 1'b1};
  end

  assign match_vec_nxt = shifted & eq_vec;

  // Test the bit at the effective pattern length; lengths beyond the top
  // are taken as the top, zero never hits
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (match_vec_nxt[k] &&
          ((LEN_W'(k + 1) == pattern_length) ||
           ((k == PATTERN_MAX - 1) && (pattern_length > LEN_W'(PATTERN_MAX))))) begin
        hit = 1'b1;
      end
    end
  end

  // Record the first match and advance the saturating position
  always_comb begin
    found_nxt = found_r;
    end_nxt   = end_r;
    if (hit && !found_r) begin
      found_nxt = 1'b1;
      end_nxt   = pos_r;
    end
    pos_nxt = (pos_r == POS_TOP) ? pos_r : pos_r + 1'b1;
  end

  // Result of the current byte if it closes the text
  assign result.found     = found_nxt;
  assign result.match_end = found_nxt ? end_nxt : '0;

  // Hold state; clear it after the final byte of a text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_vec_r <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      end_r       <= '0;
    end else if (step) begin
      if (last_char) begin
        match_vec_r <= '0;
        pos_r       <= '0;
        found_r     <= 1'b0;
        end_r       <= '0;
      end else begin
        match_vec_r <= match_vec_nxt;
        pos_r       <= pos_nxt;
        found_r     <= found_nxt;
        end_r       <= end_nxt;
      end
    end
  end

  // A closing byte leaves the state cleared for the next text
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_char |=> (pos_r == '0) && (match_vec_r == '0) && !found_r)
    else $error("search state not cleared after final byte");

  // Without a recorded match the stored end stays at zero
  a_end_zero_unfound: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (end_r == '0))
    else $error("match end set without a match");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard substring matcher.
// A short table of directed texts and register writes comes first. It covers
// the empty pattern, case folding, the wildcard, a match on the final byte, an
// oversized length, an ignored register index and a write in the middle of a
// text. Random texts follow in four idling phases.
// Every accepted final byte queues a result from an in-bench shift-and model,
// and each result transfer is checked against the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import wsm_pkg::*;

  localparam logic [1:0]  REG_UNUSED    = 2'd3;   // index past the register map
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SEG_BYTES     = 106;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned SEND_IDLE [4] = '{0, 74, 0, 12};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 74, 12};

  typedef enum logic {ROW_CFG, ROW_TEXT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] value;      // register data of a write row
    logic [7:0]  chr;
    logic        last;       // flag on the final repeat only
    logic [31:0] reps;
    logic        typed;      // expected result given in the row
    logic        exp_found;
    logic [15:0] exp_end;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [63:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] text_char
  logic        in_tlast   = 1'b0; // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [0] found, [16:1] match_end

  // Search model state and its copy of the registers
  logic [63:0] pat_low   = '0;
  logic [63:0] pat_high  = '0;
  logic [4:0]  pat_len   = '0;
  logic [15:0] shift_vec = '0;
  logic [15:0] text_pos  = '0;
  logic        seen_hit  = 1'b0;
  logic [15:0] first_end = '0;

  wsm_result_t results_due[$];
  int unsigned faults         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  logic        want_hold      = 1'b0;
  stim_row_t   plan [19];

  wildcard_substring_matcher_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned i);
    return (i < 8) ? pat_low[8*i +: 8] : pat_high[8*(i-8) +: 8];
  endfunction

  function automatic int unsigned active_length();
    return (pat_len > PAT_MAX_DEF) ? PAT_MAX_DEF : pat_len;
  endfunction

  // Advance the search by one text byte; a final byte yields a result
  task automatic step_search(input logic [7:0] c_in, input logic last,
                             output logic has_res, output wsm_result_t res);
    logic [7:0]  c;
    logic [15:0] eq;
    int unsigned n;
    c = lower_ascii(c_in);
    n = active_length();
    for (int i = 0; i < 16; i++) begin
      eq[i] = (pattern_byte(i) == WILDCARD_CHAR) || (lower_ascii(pattern_byte(i)) == c);
    end
    shift_vec = ((shift_vec << 1) | 16'd1) & eq;
    if (n != 0 && !seen_hit && shift_vec[n-1]) begin
      seen_hit  = 1'b1;
      first_end = text_pos;
    end
    if (text_pos != POS_TOP) text_pos = text_pos + 16'd1;
    has_res       = last;
    res.found     = seen_hit;
    res.match_end = seen_hit ? first_end : '0;
    if (last) begin
      shift_vec = '0;
      text_pos  = '0;
      seen_hit  = 1'b0;
      first_end = '0;
    end
  endtask

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= REPORT_MAX) $display("%s", msg);
  endtask

  // Offer one byte, idling first at the phase's rate, and queue its result
  task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
                           input logic exp_found, input logic [15:0] exp_end);
    logic        has_res;
    wsm_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    step_search(c, last, has_res, res);
    if (has_res) begin
      if (typed) begin
        res.found     = exp_found;
        res.match_end = exp_end;
      end
      results_due.push_back(res);
    end
  endtask

  // Stop sending and hold until every queued result has been seen
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_PAT_LOW:  pat_low  = value;
      REG_PAT_HIGH: pat_high = value;
      REG_PAT_LEN:  pat_len  = value[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] make_pattern_char();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return WILDCARD_CHAR;
    if (r < 7) return (8'h61 + 8'($urandom_range(3))) ^ (8'($urandom_range(1)) << 5);
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] filler_char();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return (8'h61 + 8'($urandom_range(3))) ^ (8'($urandom_range(1)) << 5);
  endfunction

  task automatic load_pattern(input logic [4:0] len_sel);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] junk;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = make_pattern_char();
      hi[8*i +: 8] = make_pattern_char();
    end
    junk = {$urandom, $urandom};
    write_reg(REG_UNUSED, junk);
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_PAT_LEN, {junk[63:5], len_sel});
  endtask

  // Build one text: mostly a full occurrence, some cut short, some noise
  task automatic send_text(output int unsigned n_sent);
    logic [7:0]  txt[$];
    logic [7:0]  p;
    int unsigned n;
    int unsigned kind;
    int unsigned cut;
    n    = active_length();
    kind = $urandom_range(99);
    repeat ($urandom_range(4)) txt.push_back(filler_char());
    if (kind < 85 && n != 0) begin
      cut = (kind < 70) ? n : $urandom_range(n - 1);
      for (int i = 0; i < cut; i++) begin
        p = pattern_byte(i);
        if (p == WILDCARD_CHAR) txt.push_back(8'($urandom_range(255)));
        else if (lower_ascii(p) >= "a" && lower_ascii(p) <= "z")
          txt.push_back(p ^ (8'($urandom_range(1)) << 5));
        else txt.push_back(p);
      end
    end
    repeat ($urandom_range(4)) txt.push_back(filler_char());
    if (txt.size() == 0) txt.push_back(filler_char());
    for (int i = 0; i < txt.size(); i++) begin
      send_byte(txt[i], i == txt.size() - 1, 1'b0, 1'b0, '0);
    end
    n_sent = txt.size();
  endtask

  // Result side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (want_hold) begin
      hold_left = HOLD_CYCLES;
      want_hold = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    wsm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        log_fault($sformatf("unexpected result: found=%0b end=%0d",
                            out_tdata[0], out_tdata[16:1]));
      end else begin
        want = results_due.pop_front();
        if (out_tdata[0] !== want.found || out_tdata[16:1] !== want.match_end)
          log_fault($sformatf("mismatch: expected found=%0b end=%0d, got found=%0b end=%0d",
                              want.found, want.match_end, out_tdata[0], out_tdata[16:1]));
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #16_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned n_text;
    int unsigned waited;
    logic [4:0]  len_sel;

    // Empty pattern straight after reset
    plan[0]  = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'h61, 1'b1, 32'd1, 1'b1, 1'b0, 16'd0};
    // Pattern "a.C": upper-case text, wildcard over 0xFF, hit on the final byte
    plan[1]  = '{ROW_CFG, REG_PAT_LOW, 64'h43_2E_61, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[2]  = '{ROW_CFG, REG_PAT_LEN, 64'd3, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[3]  = '{ROW_CFG, REG_UNUSED, 64'd0, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[4]  = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'h78, 1'b0, 32'd1, 1'b0, 1'b0, 16'd0};
    plan[5]  = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'h41, 1'b0, 32'd1, 1'b0, 1'b0, 16'd0};
    plan[6]  = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'hFF, 1'b0, 32'd1, 1'b0, 1'b0, 16'd0};
    plan[7]  = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'h63, 1'b1, 32'd1, 1'b1, 1'b1, 16'd3};
    // No match leaves the end position at zero
    plan[8]  = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'h00, 1'b1, 32'd1, 1'b1, 1'b0, 16'd0};
    // All-ones registers: length 31 is cut to sixteen characters of 0xFF
    plan[9]  = '{ROW_CFG, REG_PAT_LOW, '1, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[10] = '{ROW_CFG, REG_PAT_HIGH, '1, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[11] = '{ROW_CFG, REG_PAT_LEN, '1, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[12] = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'hFF, 1'b0, 32'd15, 1'b0, 1'b0, 16'd0};
    plan[13] = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'hFF, 1'b1, 32'd1, 1'b1, 1'b1, 16'd15};
    // Length shortened mid-text keeps the partial match of "qz"
    plan[14] = '{ROW_CFG, REG_PAT_LOW, 64'h7A71, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[15] = '{ROW_CFG, REG_PAT_LEN, 64'd5, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[16] = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'h71, 1'b0, 32'd1, 1'b0, 1'b0, 16'd0};
    plan[17] = '{ROW_CFG, REG_PAT_LEN, 64'd2, 8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0};
    plan[18] = '{ROW_TEXT, REG_UNUSED, 64'd0, 8'h5A, 1'b1, 32'd1, 1'b1, 1'b1, 16'd1};

    // Synchronous reset, then release on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_reg(plan[r].reg_idx, plan[r].value);
      end else begin
        for (int k = 0; k < plan[r].reps; k++) begin
          send_byte(plan[r].chr, plan[r].last && (k == plan[r].reps - 1),
                    plan[r].typed, plan[r].exp_found, plan[r].exp_end);
        end
      end
    end

    // Random texts: four idling phases, two pattern settings each
    for (int ph = 0; ph < 4; ph++) begin
      for (int seg = 0; seg < 2; seg++) begin
        case (ph * 2 + seg)
          0:       len_sel = 5'd1;
          1:       len_sel = 5'd16;
          2:       len_sel = 5'd0;
          3:       len_sel = 5'd31;
          4:       len_sel = 5'd17;
          default: len_sel = 5'($urandom_range(2, 15));
        endcase
        load_pattern(len_sel);
        send_idle_pct  = SEND_IDLE[ph];
        recv_stall_pct = RECV_STALL[ph];
        // Back-pressure the output long enough for the input to stall
        if (ph == 0 && seg == 0) want_hold = 1'b1;
        sent = 0;
        while (sent < SEG_BYTES) begin
          send_text(n_text);
          sent += n_text;
        end
      end
    end

    // Wait out the tail, bounded
    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (results_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      log_fault($sformatf("%0d expected results never arrived", results_due.size()));

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
